// ===== src/fcc_pkg.sv =====
// Shared types, constants and helper functions for the fractal cell classifier.
// Used by every module of the block; depends on nothing.
package fcc_pkg;

    // Problem dimensions
    localparam int MAX_DIM      = 64;
    localparam int MAX_ITER     = 16;
    localparam int PALETTE_SIZE = 8;
    localparam int FRAC_BITS    = 12;
    localparam int MIN_ESCAPE   = 4;
    localparam int XOR_MOD      = 5;
    localparam int XOR_LIMIT    = 2;

    // Field widths
    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int ZOOM_W  = 13;
    localparam int C_W     = 14;
    localparam int MODE_W  = 2;
    localparam int COLOR_W = $clog2(PALETTE_SIZE);
    localparam int SCORE_W = 13;
    localparam int ITER_W  = $clog2(MAX_ITER + 1);

    // Coordinate mapping divider
    localparam int NUM_W       = 9;                    // |3*(2*col - cols)| <= 378
    localparam int MAP_SHIFT   = 2 * FRAC_BITS;
    localparam int MAG_W       = NUM_W + MAP_SHIFT;
    localparam int DEN_W       = 20;                   // 2*zoom*cols < 2^20
    localparam int DIV_BITS    = 21;                   // quotient up to 2^21-1, then clamped
    localparam int DV_W        = DEN_W + DIV_BITS - 1;
    localparam int DCNT_W      = $clog2(DIV_BITS);
    localparam int START_LIMIT = 1 << 20;
    localparam int LANES       = 2;                    // lane 0: real, lane 1: imaginary

    // Iteration datapath
    localparam int Z_W        = 32;
    localparam int ZIN_W      = 22;                    // start point needs +-2^20
    localparam int P_W        = 2 * ZIN_W;
    localparam int BIG_LIMIT  = 2 << FRAC_BITS;        // |z| component above 2.0 escapes
    localparam int ESC_LIMIT  = 4 << (2 * FRAC_BITS);

    // x mod 5 on 6-bit values via reciprocal multiply
    localparam int XOR_RECIP    = 205;
    localparam int XOR_RECIP_SH = 10;

    // Register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [IDX_W-1:0] REG_ZOOM       = 3'd1;
    localparam logic [IDX_W-1:0] REG_C_RE       = 3'd2;
    localparam logic [IDX_W-1:0] REG_C_IM       = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIER_SHIFT = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROWS       = 3'd5;
    localparam logic [IDX_W-1:0] REG_COLS       = 3'd6;

    localparam logic [MODE_W-1:0] MODE_JULIA      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIERPINSKI = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XOR        = 2'd2;

    localparam logic [MODE_W-1:0]       RST_MODE  = MODE_JULIA;
    localparam logic [ZOOM_W-1:0]       RST_ZOOM  = 13'd4096;
    localparam logic signed [C_W-1:0]   RST_C_RE  = -14'sd2867;
    localparam logic signed [C_W-1:0]   RST_C_IM  = 14'sd1107;
    localparam logic                    RST_SHIFT = 1'b0;
    localparam logic [DIM_W-1:0]        RST_ROWS  = 7'd8;
    localparam logic [DIM_W-1:0]        RST_COLS  = 7'd13;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } t_in_item;

    typedef struct packed {
        logic               place;
        logic [COLOR_W-1:0] color_index;
        logic [SCORE_W-1:0] score;
    } t_out_item;

    typedef struct packed {
        logic [MODE_W-1:0]     fractal_mode;
        logic [ZOOM_W-1:0]     julia_zoom;
        logic signed [C_W-1:0] julia_c_re;
        logic signed [C_W-1:0] julia_c_im;
        logic                  sierpinski_shift;
        logic [DIM_W-1:0]      grid_rows;
        logic [DIM_W-1:0]      grid_cols;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic load_z;
        logic mul;
        logic upd;
        logic iter_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic julia;
        logic div_last;
        logic escaped;
        logic iter_last;
    } t_status;

    function automatic logic [SCORE_W-1:0] score_lookup(input logic [COLOR_W-1:0] color);
        logic [SCORE_W-1:0] s;
        case (color)
            3'd0:    s = 13'd10;
            3'd1:    s = 13'd50;
            3'd2:    s = 13'd100;
            3'd3:    s = 13'd150;
            3'd4:    s = 13'd250;
            3'd5:    s = 13'd400;
            3'd6:    s = 13'd1010;
            default: s = 13'd5000;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] mod5_small(input logic [COORD_W-1:0] x);
        logic [COORD_W+7:0] prod;
        logic [3:0]         q;
        logic [COORD_W-1:0] r;
        prod = x * 8'(XOR_RECIP);
        q    = prod[COORD_W+7:XOR_RECIP_SH];
        r    = x - COORD_W'(q) * COORD_W'(XOR_MOD);
        return r[2:0];
    endfunction

endpackage

// ===== src/fcc_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on fcc_pkg.
module fcc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcc_pkg::APB_AW-1:0]   paddr,
    input  logic [fcc_pkg::APB_DW-1:0]   pwdata,
    output logic [fcc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output fcc_pkg::t_cfg                o_cfg
);

    fcc_pkg::t_cfg                   r_cfg;
    logic [fcc_pkg::IDX_W-1:0]       idx;
    logic                            wr;

    assign idx    = paddr[fcc_pkg::APB_AW-1:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fractal_mode     <= fcc_pkg::RST_MODE;
            r_cfg.julia_zoom       <= fcc_pkg::RST_ZOOM;
            r_cfg.julia_c_re       <= fcc_pkg::RST_C_RE;
            r_cfg.julia_c_im       <= fcc_pkg::RST_C_IM;
            r_cfg.sierpinski_shift <= fcc_pkg::RST_SHIFT;
            r_cfg.grid_rows        <= fcc_pkg::RST_ROWS;
            r_cfg.grid_cols        <= fcc_pkg::RST_COLS;
        end else if (wr) begin
            case (idx)
                fcc_pkg::REG_MODE:       r_cfg.fractal_mode <= pwdata[fcc_pkg::MODE_W-1:0];
                fcc_pkg::REG_ZOOM:       r_cfg.julia_zoom   <= pwdata[fcc_pkg::ZOOM_W-1:0];
                fcc_pkg::REG_C_RE:       r_cfg.julia_c_re   <= $signed(pwdata[fcc_pkg::C_W-1:0]);
                fcc_pkg::REG_C_IM:       r_cfg.julia_c_im   <= $signed(pwdata[fcc_pkg::C_W-1:0]);
                fcc_pkg::REG_SIER_SHIFT: r_cfg.sierpinski_shift <= pwdata[0];
                fcc_pkg::REG_ROWS:       r_cfg.grid_rows    <= pwdata[fcc_pkg::DIM_W-1:0];
                fcc_pkg::REG_COLS:       r_cfg.grid_cols    <= pwdata[fcc_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            fcc_pkg::REG_MODE:       prdata = fcc_pkg::APB_DW'(r_cfg.fractal_mode);
            fcc_pkg::REG_ZOOM:       prdata = fcc_pkg::APB_DW'(r_cfg.julia_zoom);
            fcc_pkg::REG_C_RE:       prdata = fcc_pkg::APB_DW'(r_cfg.julia_c_re);
            fcc_pkg::REG_C_IM:       prdata = fcc_pkg::APB_DW'(r_cfg.julia_c_im);
            fcc_pkg::REG_SIER_SHIFT: prdata = fcc_pkg::APB_DW'(r_cfg.sierpinski_shift);
            fcc_pkg::REG_ROWS:       prdata = fcc_pkg::APB_DW'(r_cfg.grid_rows);
            fcc_pkg::REG_COLS:       prdata = fcc_pkg::APB_DW'(r_cfg.grid_cols);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/fcc_ctrl.sv =====
// Sequencing state machine and output valid flag for the classifier.
// Depends on fcc_pkg; drives commands into fcc_datapath.
module fcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  fcc_pkg::t_status   i_status,
    output fcc_pkg::t_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_LOADZ = 9'b000001000,
        S_MUL0  = 9'b000010000,
        S_UPD   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ESC   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.julia ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_LOADZ;
                end
            end
            S_LOADZ: begin
                o_cmd.load_z = 1'b1;
                n_state      = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ESC;
            end
            S_ESC: begin
                if (i_status.escaped) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.iter_inc = 1'b1;
                    n_state        = i_status.iter_last ? S_FIN : S_UPD;
                end
            end
            S_FIN: begin
                // output register frees up when empty or being taken this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid & i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/fcc_datapath.sv =====
// Datapath: cell capture, coordinate mapping divider, Julia iteration unit,
// pattern modes and the output register. Depends on fcc_pkg; driven by fcc_ctrl.
module fcc_datapath (
    input  logic                i_clk,
    input  fcc_pkg::t_in_item   i_in_item,
    input  fcc_pkg::t_cfg       i_cfg,
    input  fcc_pkg::t_cmd       i_cmd,
    output fcc_pkg::t_status    o_status,
    output fcc_pkg::t_out_item  o_out_item
);

    localparam int LANE_W = $clog2(fcc_pkg::LANES);

    logic [fcc_pkg::COORD_W-1:0]  r_row, r_col;
    logic [fcc_pkg::MAG_W-1:0]    r_rem [fcc_pkg::LANES];
    logic [fcc_pkg::DV_W-1:0]     r_dv  [fcc_pkg::LANES];
    logic [fcc_pkg::DIV_BITS-1:0] r_q   [fcc_pkg::LANES];
    logic                         r_neg [fcc_pkg::LANES];
    logic [fcc_pkg::DCNT_W-1:0]   r_dcnt;
    logic signed [fcc_pkg::Z_W-1:0] r_re, r_im;
    logic signed [fcc_pkg::P_W-1:0] r_p_rr, r_p_ii, r_p_ri;
    logic [fcc_pkg::ITER_W-1:0]   r_iter;
    fcc_pkg::t_out_item           r_out;

    // grid and mapping operands
    logic [fcc_pkg::DIM_W-1:0]       rows_eff, cols_eff;
    logic [fcc_pkg::ZOOM_W-1:0]      zoom_eff;
    logic [fcc_pkg::ZOOM_W+fcc_pkg::DIM_W-1:0] zc, zr;
    logic [fcc_pkg::DEN_W-1:0]       den [fcc_pkg::LANES];
    logic signed [fcc_pkg::NUM_W-1:0] d_re, d_im;
    logic [fcc_pkg::NUM_W-1:0]       num [fcc_pkg::LANES];
    logic                            num_neg [fcc_pkg::LANES];
    logic                            in_grid;

    // divider step
    logic                            ge [fcc_pkg::LANES];
    logic [fcc_pkg::DIV_BITS-1:0]    qc [fcc_pkg::LANES];
    logic signed [fcc_pkg::Z_W-1:0]  zmag [fcc_pkg::LANES];
    logic signed [fcc_pkg::Z_W-1:0]  z0 [fcc_pkg::LANES];

    // iteration
    logic signed [fcc_pkg::ZIN_W-1:0] re_in, im_in;
    logic signed [fcc_pkg::P_W:0]     diff, mag2;
    logic signed [fcc_pkg::Z_W-1:0]   n_re, n_im;
    logic                             big;

    // result
    logic                             res_place;
    logic [fcc_pkg::COLOR_W-1:0]      res_color;
    logic [2:0]                       sum3, prod3;
    logic [fcc_pkg::COORD_W-1:0]      x_xor;
    fcc_pkg::t_out_item               n_out;

    always_comb begin
        rows_eff = (i_cfg.grid_rows > fcc_pkg::DIM_W'(fcc_pkg::MAX_DIM))
                 ? fcc_pkg::DIM_W'(fcc_pkg::MAX_DIM) : i_cfg.grid_rows;
        cols_eff = (i_cfg.grid_cols > fcc_pkg::DIM_W'(fcc_pkg::MAX_DIM))
                 ? fcc_pkg::DIM_W'(fcc_pkg::MAX_DIM) : i_cfg.grid_cols;
        zoom_eff = (i_cfg.julia_zoom == '0) ? fcc_pkg::ZOOM_W'(1) : i_cfg.julia_zoom;
        in_grid  = ({1'b0, r_row} < rows_eff) && ({1'b0, r_col} < cols_eff);

        zc = zoom_eff * cols_eff;
        zr = zoom_eff * rows_eff;
        den[0] = fcc_pkg::DEN_W'({zc, 1'b0});
        den[1] = fcc_pkg::DEN_W'(zr);

        d_re = $signed({2'b00, r_col, 1'b0}) - $signed({2'b00, cols_eff});
        d_im = $signed({2'b00, r_row, 1'b0}) - $signed({2'b00, rows_eff});
        num_neg[0] = d_re[fcc_pkg::NUM_W-1];
        num_neg[1] = d_im[fcc_pkg::NUM_W-1];
        num[0] = fcc_pkg::NUM_W'(3) * (num_neg[0] ? fcc_pkg::NUM_W'(-d_re)
                                                  : fcc_pkg::NUM_W'(d_re));
        num[1] = num_neg[1] ? fcc_pkg::NUM_W'(-d_im) : fcc_pkg::NUM_W'(d_im);
    end

    always_comb begin
        for (int l = 0; l < fcc_pkg::LANES; l++) begin
            ge[l]   = fcc_pkg::DV_W'(r_rem[l]) >= r_dv[l];
            qc[l]   = (r_q[l] > fcc_pkg::DIV_BITS'(fcc_pkg::START_LIMIT))
                    ? fcc_pkg::DIV_BITS'(fcc_pkg::START_LIMIT) : r_q[l];
            zmag[l] = $signed(fcc_pkg::Z_W'(qc[l]));
            z0[l]   = r_neg[l] ? -zmag[l] : zmag[l];
        end
    end

    always_comb begin
        re_in = $signed(r_re[fcc_pkg::ZIN_W-1:0]);
        im_in = $signed(r_im[fcc_pkg::ZIN_W-1:0]);
        diff  = r_p_rr - r_p_ii;
        // floor(2*re*im / 2^12) is an arithmetic shift by one bit less
        n_re  = fcc_pkg::Z_W'(diff >>> fcc_pkg::FRAC_BITS) + fcc_pkg::Z_W'(i_cfg.julia_c_re);
        n_im  = fcc_pkg::Z_W'(r_p_ri >>> (fcc_pkg::FRAC_BITS - 1))
              + fcc_pkg::Z_W'(i_cfg.julia_c_im);
        mag2  = r_p_rr + r_p_ii;
        // a component beyond 2.0 has escaped; the squares are then not exact
        big   = (r_re > fcc_pkg::BIG_LIMIT) || (r_re < -fcc_pkg::BIG_LIMIT)
             || (r_im > fcc_pkg::BIG_LIMIT) || (r_im < -fcc_pkg::BIG_LIMIT);
    end

    assign o_status.julia     = in_grid && (i_cfg.fractal_mode == fcc_pkg::MODE_JULIA);
    assign o_status.div_last  = (r_dcnt == fcc_pkg::DCNT_W'(fcc_pkg::DIV_BITS - 1));
    assign o_status.escaped   = big || (mag2 > fcc_pkg::ESC_LIMIT);
    assign o_status.iter_last = (r_iter == fcc_pkg::ITER_W'(fcc_pkg::MAX_ITER - 1));

    always_comb begin
        sum3  = r_row[2:0] + r_col[2:0];
        prod3 = 3'(r_row[2:0] * r_col[2:0]);
        x_xor = r_row ^ r_col;
        res_place = 1'b0;
        res_color = '0;
        case (i_cfg.fractal_mode)
            fcc_pkg::MODE_JULIA: begin
                res_place = (r_iter >= fcc_pkg::ITER_W'(fcc_pkg::MIN_ESCAPE))
                         && (r_iter <  fcc_pkg::ITER_W'(fcc_pkg::MAX_ITER));
                res_color = r_iter[fcc_pkg::COLOR_W-1:0];
            end
            fcc_pkg::MODE_SIERPINSKI: begin
                res_place = ((r_row & r_col) == '0);
                res_color = i_cfg.sierpinski_shift ? {sum3[1:0], 1'b0} : sum3;
            end
            fcc_pkg::MODE_XOR: begin
                res_place = (fcc_pkg::mod5_small(x_xor) < 3'(fcc_pkg::XOR_LIMIT));
                res_color = prod3;
            end
            default: begin
                res_place = 1'b0;
            end
        endcase
        n_out.place       = res_place & in_grid;
        n_out.color_index = n_out.place ? res_color : '0;
        n_out.score       = n_out.place ? fcc_pkg::score_lookup(res_color) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_in_item.cell_row;
            r_col <= i_in_item.cell_col;
        end

        if (i_cmd.prep) begin
            r_dcnt <= '0;
            r_iter <= '0;
            for (int l = 0; l < fcc_pkg::LANES; l++) begin
                r_rem[l] <= {num[l], fcc_pkg::MAP_SHIFT'(0)};
                r_dv[l]  <= {den[l], (fcc_pkg::DIV_BITS - 1)'(0)};
                r_q[l]   <= '0;
                r_neg[l] <= num_neg[l];
            end
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            for (int l = 0; l < fcc_pkg::LANES; l++) begin
                if (ge[l]) begin
                    r_rem[l] <= r_rem[l] - r_dv[l][fcc_pkg::MAG_W-1:0];
                end
                r_dv[l] <= r_dv[l] >> 1;
                r_q[l]  <= {r_q[l][fcc_pkg::DIV_BITS-2:0], ge[l]};
            end
        end

        if (i_cmd.iter_inc) begin
            r_iter <= r_iter + 1'b1;
        end

        if (i_cmd.load_z) begin
            r_re <= z0[LANE_W'(0)];
            r_im <= z0[LANE_W'(1)];
        end else if (i_cmd.upd) begin
            r_re <= n_re;
            r_im <= n_im;
        end

        if (i_cmd.mul) begin
            r_p_rr <= re_in * re_in;
            r_p_ii <= im_in * im_in;
            r_p_ri <= re_in * im_in;
        end

        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== src/fractal_cell_classifier_core.sv =====
// Top level of the fractal cell classifier: register file, controller, datapath.
// Depends on fcc_pkg, fcc_regs, fcc_ctrl and fcc_datapath.
//
// Classifies one grid cell per item: returns whether a brick is placed, its palette
// index and its score. Sierpinski and XOR modes, cells outside the grid and the
// unused mode code go from capture through a preparation state straight to the
// output load. Julia mode maps the cell into the plane with a restoring divider
// (21-bit quotient, both coordinates in parallel), loads and squares z, then
// repeats update, multiply and escape test on the shared complex-square unit, up
// to 16 iterations. One item is in work at a time; a new item is taken while a
// finished result still waits on the output. The user must write the configuration
// registers over APB only while the block is idle; the block does not enforce it.
module fractal_cell_classifier_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  fcc_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output fcc_pkg::t_out_item           o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcc_pkg::APB_AW-1:0]   paddr,
    input  logic [fcc_pkg::APB_DW-1:0]   pwdata,
    output logic [fcc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    fcc_pkg::t_cfg    cfg;
    fcc_pkg::t_cmd    cmd;
    fcc_pkg::t_status status;

    fcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    fcc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_in_item  (i_in_item),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule
